FILE: rtl/at_set_command_parser_unit_macros.svh
// ---------------------------------------------------------------------------
// at_set_command_parser_unit_macros.svh
// Assertion macros shared by the parser RTL. They compile to nothing when
// SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef AT_SET_COMMAND_PARSER_UNIT_MACROS_SVH
`define AT_SET_COMMAND_PARSER_UNIT_MACROS_SVH

`ifndef SYNTHESIS

// Property holds at every clock edge outside reset
`define ATSCP_ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("atscp assertion failed");

// Consequent holds in the same cycle as the antecedent
`define ATSCP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("atscp assertion failed");

// Consequent holds in the cycle after the antecedent
`define ATSCP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("atscp assertion failed");

`else

`define ATSCP_ASSERT_ALWAYS(label, clk, rst, prop)
`define ATSCP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ATSCP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/atscp_pkg.sv
// ---------------------------------------------------------------------------
// atscp_pkg
// Types and constants shared by the AT set-command parser modules.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package atscp_pkg;

   // Frame length saturation limit and counter width
   localparam int REC_LEN     = 256;
   localparam int CNT_W       = $clog2(REC_LEN + 1);
   localparam int FRAME_LEN_W = 9;

   // Frame buffer
   localparam int KEEP_BYTES  = 12;
   localparam int WIN_START   = 7;
   localparam int WIN_LEN     = 5;
   localparam int WIN_LEN_W   = $clog2(WIN_LEN + 1);
   localparam int WIN_A_LEN   = 3;
   localparam int LEN_A       = 12;
   localparam int LEN_VW      = 14;

   // Value and register widths
   localparam int MAG_W       = 17;
   localparam int VALUE_W     = MAG_W + 1;
   localparam int SET_W       = 32;
   localparam int V_W         = 16;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Characters
   localparam logic [7:0] CH_A     = 8'h41;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_LT    = 8'h74;
   localparam logic [7:0] CH_V     = 8'h56;
   localparam logic [7:0] CH_W     = 8'h57;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // Input word kind
   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_IDLE = 1'b1
   } op_type;

   // Register selected by a frame
   typedef enum logic [1:0] {
      TGT_NONE = 2'd0,
      TGT_A    = 2'd1,
      TGT_V    = 2'd2,
      TGT_W    = 2'd3
   } target_type;

   // One classified frame handed from front to back
   typedef struct packed {
      target_type                    target;
      logic [WIN_LEN-1:0][7:0]       window;
      logic [CNT_W-1:0]              frame_length;
   } job_type;

   // Queue status
   typedef struct packed {
      logic full;
      logic not_empty;
   } fifo_stat_type;

endpackage

`default_nettype wire

FILE: rtl/atscp_fifo.sv
// ---------------------------------------------------------------------------
// atscp_fifo
// Two-entry queue of classified frames between the front and back parts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "at_set_command_parser_unit_macros.svh"

module atscp_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire atscp_pkg::job_type     push_job,
   input  wire logic                   pop,
   output atscp_pkg::job_type          pop_job,
   output atscp_pkg::fifo_stat_type    stat
);
   import atscp_pkg::*;

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   // Pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign pop_job        = slot_ff[rd_ptr_ff];
   assign stat.full      = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
   assign stat.not_empty = (cnt_ff != '0);

   // Checks
   `ATSCP_ASSERT_ALWAYS(a_fifo_cnt_range, clock, reset, cnt_ff <= QCNT_W'(QUEUE_DEPTH))
   `ATSCP_ASSERT_IMPLY(a_fifo_no_overflow, clock, reset, stat.full, !push)
   `ATSCP_ASSERT_IMPLY(a_fifo_no_underflow, clock, reset, cnt_ff == '0, !pop)

endmodule

`default_nettype wire

FILE: rtl/atscp_front.sv
// ---------------------------------------------------------------------------
// atscp_front
// Accepts words, collects the frame head and length, and classifies the
// frame on an armed idle event into a job for the back part.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "at_set_command_parser_unit_macros.svh"

module atscp_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic                   op,
   input  wire logic [7:0]             data_byte,
   input  wire atscp_pkg::fifo_stat_type stat,
   output logic                        push,
   output atscp_pkg::job_type          job
);
   import atscp_pkg::*;

   logic [7:0]       buf_ff [KEEP_BYTES];
   logic [7:0]       buf_in [KEEP_BYTES];
   logic [CNT_W-1:0] count_ff, count_in;
   logic             armed_ff, armed_in;
   logic             accept;
   logic             is_byte;
   logic             head_ok;

   assign req_tready = !stat.full;
   assign accept     = req_tvalid && req_tready;
   assign is_byte    = (op == OP_BYTE);
   assign push       = accept && !is_byte && armed_ff;

   // Common "AT+set" head
   assign head_ok = (buf_ff[0] == CH_A) && (buf_ff[1] == CH_T) && (buf_ff[2] == CH_PLUS)
                 && (buf_ff[3] == CH_S) && (buf_ff[4] == CH_E) && (buf_ff[5] == CH_LT);

   // Classify the frame held in the buffer
   always_comb begin
      job.target = TGT_NONE;
      if (head_ok && count_ff == CNT_W'(LEN_A) && buf_ff[6] == CH_A) begin
         job.target = TGT_A;
      end else if (head_ok && count_ff == CNT_W'(LEN_VW) && buf_ff[6] == CH_V) begin
         job.target = TGT_V;
      end else if (head_ok && count_ff == CNT_W'(LEN_VW) && buf_ff[6] == CH_W) begin
         job.target = TGT_W;
      end
      for (int i = 0; i < WIN_LEN; i++) begin
         job.window[i] = buf_ff[WIN_START + i];
      end
      job.frame_length = count_ff;
   end

   // Frame state update
   always_comb begin
      count_in = count_ff;
      armed_in = armed_ff;
      for (int i = 0; i < KEEP_BYTES; i++) begin
         buf_in[i] = buf_ff[i];
      end
      if (accept && is_byte) begin
         for (int i = 0; i < KEEP_BYTES; i++) begin
            if (count_ff == CNT_W'(i)) begin
               buf_in[i] = data_byte;
            end
         end
         if (count_ff < CNT_W'(REC_LEN)) begin
            count_in = count_ff + 1'b1;
         end
         armed_in = 1'b1;
      end else if (push) begin
         for (int i = 0; i < KEEP_BYTES; i++) begin
            buf_in[i] = '0;
         end
         count_in = '0;
         armed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         armed_ff <= 1'b0;
         for (int i = 0; i < KEEP_BYTES; i++) begin
            buf_ff[i] <= '0;
         end
      end else begin
         count_ff <= count_in;
         armed_ff <= armed_in;
         for (int i = 0; i < KEEP_BYTES; i++) begin
            buf_ff[i] <= buf_in[i];
         end
      end
   end

   // Checks
   `ATSCP_ASSERT_NEXT(a_front_frame_cleared, clock, reset, push, count_ff == '0 && !armed_ff)
   `ATSCP_ASSERT_ALWAYS(a_front_count_sat, clock, reset, count_ff <= CNT_W'(REC_LEN))

endmodule

`default_nettype wire

FILE: rtl/atscp_back.sv
// ---------------------------------------------------------------------------
// atscp_back
// Parses the digit window of a queued frame, updates the A, V and W
// settings and holds the result word until it is taken.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "at_set_command_parser_unit_macros.svh"

module atscp_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire atscp_pkg::job_type            job,
   input  wire atscp_pkg::fifo_stat_type      stat,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [1:0]                         target,
   output logic [atscp_pkg::VALUE_W-1:0]      parsed_value,
   output logic [atscp_pkg::SET_W-1:0]        a_setting,
   output logic [atscp_pkg::V_W-1:0]          v_setting,
   output logic [atscp_pkg::SET_W-1:0]        w_setting,
   output logic [atscp_pkg::FRAME_LEN_W-1:0]  frame_length
);
   import atscp_pkg::*;

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // Skip blanks, take an optional sign, then accumulate decimal digits
   function automatic logic [VALUE_W-1:0] parse_window(
      input logic [WIN_LEN-1:0][7:0] win,
      input logic [WIN_LEN_W-1:0]    len
   );
      logic             skipping;
      logic             in_digits;
      logic             neg;
      logic [MAG_W-1:0] mag;
      logic [7:0]       c;
      skipping  = 1'b1;
      in_digits = 1'b0;
      neg       = 1'b0;
      mag       = '0;
      for (int i = 0; i < WIN_LEN; i++) begin
         c = win[i];
         if (WIN_LEN_W'(i) < len) begin
            if (skipping) begin
               if (!is_blank(c)) begin
                  skipping = 1'b0;
                  if (c == CH_PLUS || c == CH_MINUS) begin
                     neg       = (c == CH_MINUS);
                     in_digits = 1'b1;
                  end else if (is_digit(c)) begin
                     mag       = MAG_W'(c[3:0]);
                     in_digits = 1'b1;
                  end
               end
            end else if (in_digits) begin
               if (is_digit(c)) begin
                  mag = (mag << 3) + (mag << 1) + MAG_W'(c[3:0]);
               end else begin
                  in_digits = 1'b0;
               end
            end
         end
      end
      return neg ? (VALUE_W'(0) - {1'b0, mag}) : {1'b0, mag};
   endfunction

   logic [SET_W-1:0]       a_ff, a_in;
   logic [V_W-1:0]         v_ff, v_in;
   logic [SET_W-1:0]       w_ff, w_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   target_type             rsp_target_ff;
   logic [VALUE_W-1:0]     rsp_value_ff;
   logic [CNT_W-1:0]       rsp_len_ff;
   logic [WIN_LEN_W-1:0]   win_len;
   logic [VALUE_W-1:0]     value;
   logic [SET_W-1:0]       value_ext;

   assign pop = stat.not_empty && (!rsp_valid_ff || rsp_tready);

   // Parse the window of the job at the queue head
   always_comb begin
      win_len   = (job.target == TGT_A) ? WIN_LEN_W'(WIN_A_LEN) : WIN_LEN_W'(WIN_LEN);
      value     = (job.target == TGT_NONE) ? '0 : parse_window(job.window, win_len);
      value_ext = {{(SET_W - VALUE_W){value[VALUE_W-1]}}, value};
   end

   // Setting registers change only when a job is taken
   always_comb begin
      a_in         = a_ff;
      v_in         = v_ff;
      w_in         = w_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (pop) begin
         rsp_valid_in = 1'b1;
         case (job.target)
            TGT_A:   a_in = value_ext;
            TGT_V:   v_in = value[V_W-1:0];
            TGT_W:   w_in = value_ext;
            default: a_in = a_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff         <= '0;
         v_ff         <= '0;
         w_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_ff         <= a_in;
         v_ff         <= v_in;
         w_ff         <= w_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_target_ff <= job.target;
         rsp_value_ff  <= value;
         rsp_len_ff    <= job.frame_length;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign target       = rsp_target_ff;
   assign parsed_value = rsp_value_ff;
   assign a_setting    = a_ff;
   assign v_setting    = v_ff;
   assign w_setting    = w_ff;
   assign frame_length = FRAME_LEN_W'(rsp_len_ff);

   // Checks
   `ATSCP_ASSERT_IMPLY(a_back_none_zero, clock, reset, rsp_valid_ff && rsp_target_ff == TGT_NONE, rsp_value_ff == '0)
   `ATSCP_ASSERT_IMPLY(a_back_a_match, clock, reset, rsp_valid_ff && rsp_target_ff == TGT_A, a_ff == {{(SET_W - VALUE_W){rsp_value_ff[VALUE_W-1]}}, rsp_value_ff})
   `ATSCP_ASSERT_IMPLY(a_back_v_match, clock, reset, rsp_valid_ff && rsp_target_ff == TGT_V, v_ff == rsp_value_ff[V_W-1:0])

endmodule

`default_nettype wire

FILE: rtl/at_set_command_parser_unit.sv
// An armed idle word queues a job; the back raises rsp_tvalid when it pops that job.
// Throughput: one input word per cycle while the queue has room; the two-entry queue
// and the output register let the front keep taking words while a result waits on rsp_tready.
// Byte words never produce a result; an armed idle produces exactly one.
// Reset (synchronous, active high) clears the frame buffer, length count, idle arm,
// the A/V/W settings and all queue and output valid state; no clearing pass is needed.
// ---------------------------------------------------------------------------
// at_set_command_parser_unit
// Top level of the AT set-command parser: front classifier, frame queue and
// back-end value parser with result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module at_set_command_parser_unit (
   input  wire logic          clock,
   input  wire logic          reset,
   // Request channel
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [7:0]    req_tdata,   // [7:0] data_byte
   input  wire logic [0:0]    req_tuser,   // [0] opcode
   // Result channel
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [111:0]       rsp_tdata,   // [17:0] parsed_value, [49:18] a_setting,
                                           // [65:50] v_setting, [97:66] w_setting,
                                           // [106:98] frame_length, [111:107] zero
   output logic [1:0]         rsp_tuser    // [1:0] target
);
   import atscp_pkg::*;

   job_type                 push_job;
   job_type                 pop_job;
   fifo_stat_type           stat;
   logic                    push;
   logic                    pop;
   logic [1:0]              target;
   logic [VALUE_W-1:0]      parsed_value;
   logic [SET_W-1:0]        a_setting;
   logic [V_W-1:0]          v_setting;
   logic [SET_W-1:0]        w_setting;
   logic [FRAME_LEN_W-1:0]  frame_length;

   atscp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .op         (req_tuser[0]),
      .data_byte  (req_tdata),
      .stat       (stat),
      .push       (push),
      .job        (push_job)
   );

   atscp_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .stat     (stat)
   );

   atscp_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job          (pop_job),
      .stat         (stat),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .target       (target),
      .parsed_value (parsed_value),
      .a_setting    (a_setting),
      .v_setting    (v_setting),
      .w_setting    (w_setting),
      .frame_length (frame_length)
   );

   // Pack the result word
   assign rsp_tdata = {5'b0, frame_length, w_setting, v_setting, a_setting, parsed_value};
   assign rsp_tuser = target;

endmodule

`default_nettype wire
